>>> rtl/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// No dependencies; imported by deq_cell and double_ended_queue.
`default_nettype none

package deq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CMD_W          = 3;
    localparam int STATUS_W       = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Qualified operations broadcast to every cell; at most one is set.
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
    } deq_ctl_t;

endpackage

`default_nettype wire

>>> rtl/deq_cell.sv
// One slot of the queue: a front-ordered word, a back-ordered word and an
// occupancy bit, shifted to or from its neighbors. Depends on deq_pkg.
`default_nettype none

module deq_cell
    import deq_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire deq_ctl_t                     ctl,
    input  wire logic signed [DATA_WIDTH-1:0] push_value,
    input  wire logic signed [DATA_WIDTH-1:0] a_left,
    input  wire logic signed [DATA_WIDTH-1:0] a_right,
    input  wire logic signed [DATA_WIDTH-1:0] b_left,
    input  wire logic signed [DATA_WIDTH-1:0] b_right,
    input  wire logic                         occ_left,
    input  wire logic                         occ_right,
    output logic signed [DATA_WIDTH-1:0]      a,
    output logic signed [DATA_WIDTH-1:0]      b,
    output logic                              occ
);

    logic signed [DATA_WIDTH-1:0] a_reg, a_next;
    logic signed [DATA_WIDTH-1:0] b_reg, b_next;
    logic                         occ_reg, occ_next;
    logic                         tail;

    // first free slot: the far end of each chain's opposite-side insert
    assign tail = !occ_reg && occ_left;

    always_comb
    begin
        a_next   = a_reg;
        b_next   = b_reg;
        occ_next = occ_reg;
        if (ctl.push_front)
        begin
            a_next   = a_left;
            occ_next = occ_left;
            if (tail)
            begin
                b_next = push_value;
            end
        end
        else if (ctl.push_back)
        begin
            b_next   = b_left;
            occ_next = occ_left;
            if (tail)
            begin
                a_next = push_value;
            end
        end
        else if (ctl.pop_front)
        begin
            a_next   = a_right;
            occ_next = occ_right;
        end
        else if (ctl.pop_back)
        begin
            b_next   = b_right;
            occ_next = occ_right;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign a   = a_reg;
    assign b   = b_reg;
    assign occ = occ_reg;

endmodule

`default_nettype wire

>>> rtl/double_ended_queue.sv
// Top level of the double-ended queue: command decode, a row of deq_cell
// slots and the registered result. Depends on deq_pkg and deq_cell.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid, in_stall, command, push_value  | request in
//   out     | out_valid, out_stall, popped_value,      | result out
//           | status, count, is_empty, front_value,    |
//           | back_value                               |
//
// One request per cycle while in_stall is low; its result is registered and shows the next cycle.
// All DEPTH cells shift together, so the rate is set by the cell row update.
// Reset clears occupancy, count and out_valid; stored words stay undefined.
// A held result (out_valid with out_stall) raises in_stall.
`default_nettype none

module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int CW         = $clog2(DEPTH + 1)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [CMD_W-1:0]             command,
    input  wire logic signed [DATA_WIDTH-1:0] push_value,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0]      popped_value,
    output logic [STATUS_W-1:0]               status,
    output logic [CW-1:0]                     count,
    output logic                              is_empty,
    output logic signed [DATA_WIDTH-1:0]      front_value,
    output logic signed [DATA_WIDTH-1:0]      back_value
);

    logic signed [DATA_WIDTH-1:0] a_w [DEPTH];
    logic signed [DATA_WIDTH-1:0] b_w [DEPTH];
    logic [DEPTH-1:0]             occ_w;

    logic                         accept;
    logic                         full, empty;
    logic                         want_pf, want_pb, want_of, want_ob;
    deq_ctl_t                     ctl;
    status_t                      status_next;

    logic [CW-1:0]                count_reg, count_next;
    logic                         out_valid_reg, out_valid_next;
    logic signed [DATA_WIDTH-1:0] popped_reg, popped_next;
    logic signed [DATA_WIDTH-1:0] front_reg, front_next, front_raw;
    logic signed [DATA_WIDTH-1:0] back_reg, back_next, back_raw;
    status_t                      status_reg;
    logic [CW-1:0]                count_out_reg;
    logic                         empty_reg;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign full     = occ_w[DEPTH-1];
    assign empty    = !occ_w[0];

    always_comb
    begin
        want_pf = 1'b0;
        want_pb = 1'b0;
        want_of = 1'b0;
        want_ob = 1'b0;
        unique case (command)
            CMD_PUSH_FRONT: want_pf = 1'b1;
            CMD_PUSH_BACK:  want_pb = 1'b1;
            CMD_POP_FRONT:  want_of = 1'b1;
            CMD_POP_BACK:   want_ob = 1'b1;
            default:        ;
        endcase
    end

    assign ctl.push_front = accept && want_pf && !full;
    assign ctl.push_back  = accept && want_pb && !full;
    assign ctl.pop_front  = accept && want_of && !empty;
    assign ctl.pop_back   = accept && want_ob && !empty;

    always_comb
    begin
        status_next = ST_OK;
        if ((want_pf || want_pb) && full)
        begin
            status_next = ST_FULL;
        end
        else if ((want_of || want_ob) && empty)
        begin
            status_next = ST_EMPTY;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.push_front || ctl.push_back)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctl.pop_front || ctl.pop_back)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // cell 0 of chain a is the front, cell 0 of chain b the back
    always_comb
    begin
        popped_next = '0;
        front_raw   = a_w[0];
        back_raw    = b_w[0];
        if (ctl.push_front)
        begin
            front_raw = push_value;
            if (empty)
            begin
                back_raw = push_value;
            end
        end
        else if (ctl.push_back)
        begin
            back_raw = push_value;
            if (empty)
            begin
                front_raw = push_value;
            end
        end
        else if (ctl.pop_front)
        begin
            popped_next = a_w[0];
            front_raw   = a_w[1];
        end
        else if (ctl.pop_back)
        begin
            popped_next = b_w[0];
            back_raw    = b_w[1];
        end
        front_next = (count_next == '0) ? '0 : front_raw;
        back_next  = (count_next == '0) ? '0 : back_raw;
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic signed [DATA_WIDTH-1:0] a_left, a_right, b_left, b_right;
            logic                         occ_left, occ_right;

            if (i == 0)
            begin : g_first
                assign a_left   = push_value;
                assign b_left   = push_value;
                assign occ_left = 1'b1;
            end
            else
            begin : g_mid_l
                assign a_left   = a_w[i-1];
                assign b_left   = b_w[i-1];
                assign occ_left = occ_w[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign a_right   = '0;
                assign b_right   = '0;
                assign occ_right = 1'b0;
            end
            else
            begin : g_mid_r
                assign a_right   = a_w[i+1];
                assign b_right   = b_w[i+1];
                assign occ_right = occ_w[i+1];
            end

            deq_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .push_value (push_value),
                .a_left     (a_left),
                .a_right    (a_right),
                .b_left     (b_left),
                .b_right    (b_right),
                .occ_left   (occ_left),
                .occ_right  (occ_right),
                .a          (a_w[i]),
                .b          (b_w[i]),
                .occ        (occ_w[i])
            );
        end
    endgenerate

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_reg    <= popped_next;
            status_reg    <= status_next;
            count_out_reg <= count_next;
            empty_reg     <= (count_next == '0);
            front_reg     <= front_next;
            back_reg      <= back_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = popped_reg;
    assign status       = status_reg;
    assign count        = count_out_reg;
    assign is_empty     = empty_reg;
    assign front_value  = front_reg;
    assign back_value   = back_reg;

    a_count_matches_cells: assert property (
        @(posedge clk) disable iff (!rst_n)
        $countones(occ_w) == 32'(count_reg))
        else $error("count register disagrees with cell occupancy");

    a_single_front_back: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && count == CW'(1) |-> front_value == back_value)
        else $error("front and back chains disagree on single element");

    a_full_status: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> count == CW'(DEPTH))
        else $error("full status with queue not full");

    a_empty_status: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> is_empty && popped_value == '0)
        else $error("empty status with stored elements");

endmodule

`default_nettype wire

>>> test/deq_checker.sv
// Scoreboard for double_ended_queue. It watches both channels, keeps its own
// copy of the ring contents and compares every result. Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_checker
    import deq_pkg::*;
#(
    parameter int CNT_W = $clog2(DEPTH_DEF + 1)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic [CMD_W-1:0]                 command,
    input  logic signed [DATA_WIDTH_DEF-1:0] push_value,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic signed [DATA_WIDTH_DEF-1:0] popped_value,
    input  logic [STATUS_W-1:0]              status,
    input  logic [CNT_W-1:0]                 count,
    input  logic                             is_empty,
    input  logic signed [DATA_WIDTH_DEF-1:0] front_value,
    input  logic signed [DATA_WIDTH_DEF-1:0] back_value,
    output int                               fail_count,
    output int                               outstanding
);

    localparam int QD = DEPTH_DEF;
    localparam int DW = DATA_WIDTH_DEF;
    localparam int IW = $clog2(QD);
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [DW-1:0] popped;
        status_t              st;
        logic [CNT_W-1:0]     cnt;
        logic                 empty;
        logic signed [DW-1:0] front;
        logic signed [DW-1:0] back;
    } deq_result_t;

    logic signed [DW-1:0] ring [QD];
    logic [IW-1:0]        head;
    logic [CNT_W-1:0]     occupancy;
    deq_result_t          pending_results [$];
    int                   failures = 0;

    function automatic logic [IW-1:0] slot_of(input int offset);
        return IW'(head + offset);
    endfunction

    task automatic apply_request(input logic [CMD_W-1:0] cmd,
                                 input logic signed [DW-1:0] word);
        deq_result_t r;
        r.popped = '0;
        r.st     = ST_OK;
        case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (occupancy == QD)
                    r.st = ST_FULL;
                else if (cmd == CMD_PUSH_FRONT)
                begin
                    head       = head - 1'b1;
                    ring[head] = word;
                    occupancy  = occupancy + 1'b1;
                end
                else
                begin
                    ring[slot_of(occupancy)] = word;
                    occupancy                = occupancy + 1'b1;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (occupancy == 0)
                    r.st = ST_EMPTY;
                else if (cmd == CMD_POP_FRONT)
                begin
                    r.popped  = ring[head];
                    head      = head + 1'b1;
                    occupancy = occupancy - 1'b1;
                end
                else
                begin
                    r.popped  = ring[slot_of(occupancy - 1)];
                    occupancy = occupancy - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.cnt   = occupancy;
        r.empty = (occupancy == 0);
        r.front = r.empty ? '0 : ring[head];
        r.back  = r.empty ? '0 : ring[slot_of(occupancy - 1)];
        pending_results.push_back(r);
    endtask

    task automatic check_result();
        deq_result_t e;
        if (pending_results.size() == 0)
        begin
            failures++;
            if (failures <= REPORT_LIMIT)
                $display("%0t: result with no request waiting", $realtime);
        end
        else
        begin
            e = pending_results.pop_front();
            if (popped_value !== e.popped || status !== e.st || count !== e.cnt ||
                is_empty !== e.empty || front_value !== e.front ||
                back_value !== e.back)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                begin
                    $display("%0t: mismatch, expected popped=%0d status=%0d count=%0d",
                             $realtime, e.popped, e.st, e.cnt,
                             " empty=%0b front=%0d back=%0d", e.empty, e.front, e.back);
                    $display("%0t:             actual popped=%0d status=%0d count=%0d",
                             $realtime, popped_value, status, count,
                             " empty=%0b front=%0d back=%0d", is_empty, front_value,
                             back_value);
                end
            end
        end
    endtask

    // Predict before comparing so the order within one edge never matters.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head      = '0;
            occupancy = '0;
            pending_results.delete();
            outstanding <= 0;
            fail_count  <= failures;
        end
        else
        begin
            if (in_valid && !in_stall)
                apply_request(command, push_value);
            if (out_valid && !out_stall)
                check_result();
            outstanding <= pending_results.size();
            fail_count  <= failures;
        end
    end

endmodule

>>> test/tb_top.sv
// Top of the double_ended_queue testbench: clock, reset, request stimulus
// and the verdict. Depends on deq_pkg, double_ended_queue and deq_checker.
`timescale 1ns / 1ps

module tb_top;
    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH_DEF + 1);
    localparam int PHASE_ITEMS = 140;
    localparam logic [CMD_W-1:0] CMD_LAST_CODE = '1;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic [CMD_W-1:0]                 command;
    logic signed [DATA_WIDTH_DEF-1:0] push_value;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic signed [DATA_WIDTH_DEF-1:0] popped_value;
    logic [STATUS_W-1:0]              status;
    logic [CNT_W-1:0]                 count;
    logic                             is_empty;
    logic signed [DATA_WIDTH_DEF-1:0] front_value;
    logic signed [DATA_WIDTH_DEF-1:0] back_value;

    int idle_pct;
    int stall_pct;
    int fail_count;
    int outstanding;

    always #10 clk = ~clk;

    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);

    double_ended_queue DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .popped_value (popped_value),
        .status       (status),
        .count        (count),
        .is_empty     (is_empty),
        .front_value  (front_value),
        .back_value   (back_value)
    );

    deq_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .popped_value (popped_value),
        .status       (status),
        .count        (count),
        .is_empty     (is_empty),
        .front_value  (front_value),
        .back_value   (back_value),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    function automatic logic signed [DATA_WIDTH_DEF-1:0] random_word();
        case ($urandom_range(9))
            0:       return {1'b0, {(DATA_WIDTH_DEF-1){1'b1}}};
            1:       return {1'b1, {(DATA_WIDTH_DEF-1){1'b0}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] random_command(input int push_pct,
                                                        input int pop_pct);
        int r;
        r = $urandom_range(99);
        if (r < push_pct)
            return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        else if (r < push_pct + pop_pct)
            return $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
        else
            return CMD_W'($urandom_range(CMD_QUERY, CMD_LAST_CODE));
    endfunction

    // Returns at the rising edge where the request is taken.
    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic signed [DATA_WIDTH_DEF-1:0] word);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        push_value <= word;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int left;
        int burst;
        int push_pct;
        int pop_pct;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        command    = CMD_QUERY;
        push_value = '0;
        idle_pct   = 0;
        stall_pct  = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty-queue pops, last element leaving from either end, then fill
        // to full and push once more at each end
        send_request(CMD_POP_FRONT, random_word());
        send_request(CMD_POP_BACK, random_word());
        send_request(CMD_QUERY, random_word());
        send_request(CMD_PUSH_FRONT, {1'b0, {(DATA_WIDTH_DEF-1){1'b1}}});
        send_request(CMD_POP_BACK, random_word());
        send_request(CMD_PUSH_BACK, {1'b1, {(DATA_WIDTH_DEF-1){1'b0}}});
        send_request(CMD_POP_FRONT, random_word());
        for (int i = 0; i < DEPTH_DEF; i++)
            send_request(i[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, random_word());
        send_request(CMD_PUSH_FRONT, '1);
        send_request(CMD_PUSH_BACK, {1'b0, {(DATA_WIDTH_DEF-1){1'b1}}});

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 82; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 82; end
                default: begin idle_pct = 17; stall_pct = 17; end
            endcase
            left = PHASE_ITEMS;
            while (left > 0)
            begin
                burst = $urandom_range(16, 40);
                if (burst > left)
                    burst = left;
                case ($urandom_range(2))
                    0:       begin push_pct = 70; pop_pct = 20; end
                    1:       begin push_pct = 20; pop_pct = 70; end
                    default: begin push_pct = 40; pop_pct = 40; end
                endcase
                repeat (burst)
                    send_request(random_command(push_pct, pop_pct), random_word());
                left -= burst;
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/deq_pkg.sv
rtl/deq_cell.sv
rtl/double_ended_queue.sv
test/deq_checker.sv
test/tb_top.sv
